>>> rtl/frx_pkg.sv
// frx_pkg: shared constants and types for the header/trailer frame receiver.
// No dependencies; used by frx_parser, frx_readout and the top-level receiver.
package frx_pkg;

  // Frame geometry
  localparam int PAYLOAD_WORDS = 4;
  localparam int PAYLOAD_BYTES = 4 * PAYLOAD_WORDS;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int WORD_AW       = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
  localparam int CNT_W         = $clog2(PAYLOAD_WORDS + 1);

  // Header and trailer bytes
  localparam logic [7:0] HDR_FIRST  = 8'h0D;
  localparam logic [7:0] HDR_SECOND = 8'h0A;
  localparam logic [7:0] TRL_FIRST  = 8'h0A;
  localparam logic [7:0] TRL_SECOND = 8'h0D;

  // Word write into the payload store
  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
    logic [31:0]        data;
  } frx_wr_t;

  // Readout progress, seen by the parser for its write interlock
  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] issued;
  } frx_rd_stat_t;

endpackage

>>> rtl/frx_ram.sv
// frx_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module frx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/frx_parser.sv
// frx_parser: byte-level frame sync, payload word assembly and trailer check.
// Depends on frx_pkg.
module frx_parser
  import frx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  input  frx_rd_stat_t rd_stat,
  output frx_wr_t      wr,
  output logic         frame_done
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       held;
  logic [7:0]       held_next;
  logic [23:0]      acc;
  logic [POS_W-1:0] pay_off;
  logic             in_payload;
  logic             word_end;
  logic             fire;

  assign pay_off    = pos - POS_W'(2);
  assign in_payload = (pos >= POS_W'(2)) && (pos < POS_W'(2 + PAYLOAD_BYTES));
  assign word_end   = in_payload && (pay_off[1:0] == 2'b11);

  // Hold off a word write that would overwrite a word not yet read out
  assign in_ready = !(word_end && rd_stat.active &&
                      (CNT_W'(pay_off[POS_W-1:2]) >= rd_stat.issued));
  assign fire = in_valid && in_ready;

  assign wr.en   = fire && word_end;
  assign wr.addr = WORD_AW'(pay_off[POS_W-1:2]);
  assign wr.data = {data_byte, acc};

  // Position and held byte update
  always_comb begin
    pos_next   = pos;
    held_next  = held;
    frame_done = 1'b0;
    if (pos == '0) begin
      held_next = data_byte;
      pos_next  = POS_W'(1);
    end else if (pos == POS_W'(1)) begin
      if (held == HDR_FIRST && data_byte == HDR_SECOND) begin
        pos_next = POS_W'(2);
      end else begin
        held_next = data_byte;
      end
    end else if (in_payload) begin
      pos_next = pos + POS_W'(1);
    end else if (pos == POS_W'(FRAME_BYTES - 2)) begin
      held_next = data_byte;
      pos_next  = pos + POS_W'(1);
    end else begin
      frame_done = fire && held == TRL_FIRST && data_byte == TRL_SECOND;
      held_next  = '0;
      pos_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      held <= '0;
    end else if (fire) begin
      pos  <= pos_next;
      held <= held_next;
    end
  end

  // Byte lanes gathered earliest-lowest
  always_ff @(posedge clk) begin
    if (fire && in_payload) begin
      acc <= {data_byte, acc[23:8]};
    end
  end

endmodule

>>> rtl/frx_readout.sv
// frx_readout: reads finished frame words from the payload store and drives
// the output beat register. Depends on frx_pkg.
module frx_readout
  import frx_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_done,
  input  logic [31:0]        rdata,
  output logic               re,
  output logic [WORD_AW-1:0] raddr,
  output frx_rd_stat_t       rd_stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        payload_word,
  output logic [3:0]         word_number,
  output logic               last_word
);

  logic               active;
  logic [CNT_W-1:0]   issued;
  logic               s1_v;
  logic [WORD_AW-1:0] s1_idx;
  logic               move;

  assign move  = s1_v && (!out_valid || out_ready);
  assign re    = active && (!s1_v || move);
  assign raddr = WORD_AW'(issued);

  assign rd_stat.active = active;
  assign rd_stat.issued = issued;

  // Read issue and RAM data stage
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      issued <= '0;
      s1_v   <= 1'b0;
    end else begin
      if (frame_done) begin
        active <= 1'b1;
        issued <= '0;
      end else if (re) begin
        issued <= issued + CNT_W'(1);
        if (issued == CNT_W'(PAYLOAD_WORDS - 1)) begin
          active <= 1'b0;
        end
      end
      if (re) begin
        s1_v <= 1'b1;
      end else if (move) begin
        s1_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      s1_idx <= raddr;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      payload_word <= rdata;
      word_number  <= 4'(s1_idx);
      last_word    <= (s1_idx == WORD_AW'(PAYLOAD_WORDS - 1));
    end
  end

endmodule

>>> rtl/header_trailer_frame_receiver.sv
// Fixed-length frame receiver: takes one byte beat per cycle while in_ready is
// high; after a frame's last trailer byte is accepted, the first payload word
// is offered and the rest follow one per cycle while out_ready is high, paced
// by the single-port-read store. Input stalls only when output backpressure
// lets the next frame reach a word not yet read out. Reset clears frame
// position, held byte and readout state; the payload store is not cleared.
module header_trailer_frame_receiver
  import frx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] payload_word,
  output logic [3:0]  word_number,
  output logic        last_word
);

  frx_wr_t            wr;
  frx_rd_stat_t       rd_stat;
  logic               frame_done;
  logic               re;
  logic [WORD_AW-1:0] raddr;
  logic [31:0]        rdata;

  frx_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .rd_stat    (rd_stat),
    .wr         (wr),
    .frame_done (frame_done)
  );

  // Payload store, one 32-bit word per entry
  frx_ram #(
    .WIDTH (32),
    .DEPTH (PAYLOAD_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  frx_readout u_readout (
    .clk          (clk),
    .rst          (rst),
    .frame_done   (frame_done),
    .rdata        (rdata),
    .re           (re),
    .raddr        (raddr),
    .rd_stat      (rd_stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_word (payload_word),
    .word_number  (word_number),
    .last_word    (last_word)
  );

  // A word write never lands on a word still waiting for readout
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    wr.en && rd_stat.active |-> CNT_W'(wr.addr) < rd_stat.issued)
    else $error("payload word overwritten before readout");

  // A new frame never completes while the previous one is still being read
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> !rd_stat.active)
    else $error("frame completed during readout");

  // The last beat carries the final word number
  a_last_num: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word |-> word_number == 4'(PAYLOAD_WORDS - 1))
    else $error("last word with wrong word number");

endmodule
